>>> design/ultrasonic_echo_ranger_display_top_assert.svh
// Assertion macros for the ultrasonic echo ranger checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ULTRASONIC_ECHO_RANGER_DISPLAY_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_DISPLAY_TOP_ASSERT_SVH

// Same-cycle implication.
`define UERD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define UERD_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/uerd_pkg.sv
// Shared types, constants and functions of the ultrasonic echo ranger.
// No dependencies.
`timescale 1ns / 1ps

package uerd_pkg;

  localparam int unsigned CNT_W  = 24;
  localparam int unsigned SHRT_W = 16;
  localparam int unsigned BCD_W  = 12;
  localparam int unsigned DIST_W = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFGD_W = 24;
  localparam int unsigned CFGI_W = 3;

  localparam logic [SHRT_W-1:0] SETTLE_RST  = 16'd2;
  localparam logic [SHRT_W-1:0] PULSE_RST   = 16'd15;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST = 24'd1000000;
  localparam logic [SHRT_W-1:0] TPU_RST     = 16'd150;
  localparam logic [CNT_W-1:0]  GAP_RST     = 24'd60000;

  localparam logic [WORD_W-1:0] DASHES  = 32'h4040_4040;
  localparam logic [BCD_W-1:0]  BCD_MAX = 12'h999;

  typedef enum logic [CFGI_W-1:0] {
    CFG_SETTLE  = 3'd0,
    CFG_PULSE   = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_TPU     = 3'd3,
    CFG_GAP     = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_SETTLE  = 5'b00001,
    PH_PULSE   = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_MEASURE = 5'b01000,
    PH_GAP     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [SHRT_W-1:0] settle_ticks;
    logic [SHRT_W-1:0] pulse_ticks;
    logic [CNT_W-1:0]  echo_timeout_ticks;
    logic [SHRT_W-1:0] ticks_per_unit;
    logic [CNT_W-1:0]  repeat_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic              new_reading;
    logic              timed_out;
    logic [DIST_W-1:0] distance_units;
    logic [WORD_W-1:0] display_word;
    logic              trigger_out;
  } result_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] b);
    logic [4:0] d0;
    logic [4:0] d1;
    logic [4:0] d2;
    logic [BCD_W-1:0] r;
    d0 = {1'b0, b[3:0]} + 5'd1;
    d1 = {1'b0, b[7:4]};
    d2 = {1'b0, b[11:8]};
    if (d0 > 5'd9) begin
      d0 = 5'd0;
      d1 = d1 + 5'd1;
    end
    if (d1 > 5'd9) begin
      d1 = 5'd0;
      d2 = d2 + 5'd1;
    end
    if (b >= BCD_MAX || d2 > 5'd9) begin
      r = BCD_MAX;
    end else begin
      r = {d2[3:0], d1[3:0], d0[3:0]};
    end
    return r;
  endfunction

endpackage

>>> design/uerd_disp.sv
// Seven-segment and binary view of the BCD distance counter.
// Depends on uerd_pkg.
`timescale 1ns / 1ps

module uerd_disp (
  input  logic [uerd_pkg::BCD_W-1:0]  bcd,
  output logic [uerd_pkg::WORD_W-1:0] seg_word,
  output logic [uerd_pkg::DIST_W-1:0] distance
);

  logic [3:0] dig_h;
  logic [3:0] dig_t;
  logic [3:0] dig_o;

  // clamp any non-decimal nibble to nine
  assign dig_h = (bcd[11:8] > 4'd9) ? 4'd9 : bcd[11:8];
  assign dig_t = (bcd[7:4]  > 4'd9) ? 4'd9 : bcd[7:4];
  assign dig_o = (bcd[3:0]  > 4'd9) ? 4'd9 : bcd[3:0];

  assign seg_word = {8'h00,
                     1'b0, uerd_pkg::seg_of(dig_h),
                     1'b0, uerd_pkg::seg_of(dig_t),
                     1'b0, uerd_pkg::seg_of(dig_o)};

  assign distance = ({6'd0, dig_h} * 10'd100) + ({6'd0, dig_t} * 10'd10) + {6'd0, dig_o};

endmodule

>>> design/uerd_seq.sv
// Measurement sequencer: phase, tick counter, unit prescaler, BCD counter
// and held reading. Depends on uerd_pkg.
`timescale 1ns / 1ps

module uerd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        echo_level,
  input  uerd_pkg::cfg_t              cfg,
  input  logic [uerd_pkg::WORD_W-1:0] seg_word,
  input  logic [uerd_pkg::DIST_W-1:0] seg_distance,
  output logic [uerd_pkg::BCD_W-1:0]  bcd,
  output uerd_pkg::result_t           res
);

  uerd_pkg::phase_t              phase_r, phase_nxt;
  logic [uerd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [uerd_pkg::SHRT_W-1:0]   pre_r, pre_nxt;
  logic [uerd_pkg::BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [uerd_pkg::WORD_W-1:0]   hold_r, hold_nxt;
  logic                          tout_r, tout_nxt;
  logic [uerd_pkg::DIST_W-1:0]   dist_r, dist_nxt;
  logic                          trig;
  logic                          done;
  logic                          count_hi;
  logic                          finish;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    pre_nxt   = pre_r;
    bcd_nxt   = bcd_r;
    hold_nxt  = hold_r;
    tout_nxt  = tout_r;
    dist_nxt  = dist_r;
    trig      = 1'b0;
    done      = 1'b0;
    count_hi  = 1'b0;
    finish    = 1'b0;

    // gap and settle fall straight through when their length is spent
    if (phase_nxt == uerd_pkg::PH_GAP) begin
      if (count_nxt < cfg.repeat_gap_ticks) begin
        count_nxt = count_nxt + 24'd1;
      end else begin
        phase_nxt = uerd_pkg::PH_SETTLE;
        count_nxt = '0;
      end
    end
    if (phase_nxt == uerd_pkg::PH_SETTLE) begin
      if (count_nxt < {8'd0, cfg.settle_ticks}) begin
        count_nxt = count_nxt + 24'd1;
      end else begin
        phase_nxt = uerd_pkg::PH_PULSE;
        count_nxt = '0;
      end
    end

    case (phase_nxt)
      uerd_pkg::PH_SETTLE, uerd_pkg::PH_GAP: begin
      end
      uerd_pkg::PH_PULSE: begin
        trig      = 1'b1;
        count_nxt = count_nxt + 24'd1;
        if (count_nxt >= {8'd0, cfg.pulse_ticks}) begin
          phase_nxt = uerd_pkg::PH_WAIT;
          count_nxt = '0;
        end
      end
      uerd_pkg::PH_WAIT: begin
        if (echo_level) begin
          phase_nxt = uerd_pkg::PH_MEASURE;
          count_nxt = '0;
          pre_nxt   = '0;
          bcd_nxt   = '0;
          count_hi  = 1'b1;
        end else begin
          count_nxt = count_nxt + 24'd1;
          if (count_nxt >= cfg.echo_timeout_ticks) begin
            hold_nxt  = uerd_pkg::DASHES;
            tout_nxt  = 1'b1;
            dist_nxt  = '0;
            done      = 1'b1;
            phase_nxt = uerd_pkg::PH_GAP;
            count_nxt = '0;
          end
        end
      end
      uerd_pkg::PH_MEASURE: begin
        if (echo_level) begin
          count_hi = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_nxt = uerd_pkg::PH_SETTLE;
        count_nxt = '0;
      end
    endcase

    if (count_hi) begin
      pre_nxt = pre_nxt + 16'd1;
      if (pre_nxt >= cfg.ticks_per_unit) begin
        pre_nxt = '0;
        bcd_nxt = uerd_pkg::bcd_inc(bcd_nxt);
      end
    end
    if (finish) begin
      hold_nxt  = seg_word;
      dist_nxt  = seg_distance;
      tout_nxt  = 1'b0;
      done      = 1'b1;
      phase_nxt = uerd_pkg::PH_GAP;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uerd_pkg::PH_SETTLE;
      count_r <= '0;
      pre_r   <= '0;
      bcd_r   <= '0;
      hold_r  <= '0;
      tout_r  <= 1'b0;
      dist_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      pre_r   <= pre_nxt;
      bcd_r   <= bcd_nxt;
      hold_r  <= hold_nxt;
      tout_r  <= tout_nxt;
      dist_r  <= dist_nxt;
    end
  end

  assign bcd                = bcd_r;
  assign res.trigger_out    = trig;
  assign res.display_word   = hold_nxt;
  assign res.distance_units = dist_nxt;
  assign res.timed_out      = tout_nxt;
  assign res.new_reading    = done;

endmodule

>>> design/ultrasonic_echo_ranger_display_top.sv
// Ultrasonic echo ranger: one input request per timer tick carrying the sampled
// echo level, one result request per tick with trigger drive and the held
// reading. The sequencer state advances once per accepted tick and the result
// lands in an output register, so one tick is taken every cycle while results
// are drained, and the result is presented in the cycle after its tick is taken.
// Depends on uerd_pkg, uerd_disp and uerd_seq.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_display_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [0] echo_level
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,  // [0] trigger_out, [32:1] display_word,
                                                   // [42:33] distance_units, [43] timed_out,
                                                   // [44] new_reading
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [uerd_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [uerd_pkg::CFGD_W-1:0]  cfg_data
);

  uerd_pkg::cfg_t              cfg_r;
  uerd_pkg::result_t           res;
  logic [uerd_pkg::BCD_W-1:0]  bcd;
  logic [uerd_pkg::WORD_W-1:0] seg_word;
  logic [uerd_pkg::DIST_W-1:0] seg_distance;
  logic                        step;
  logic                        out_valid_r;
  logic [47:0]                 out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks       <= uerd_pkg::SETTLE_RST;
      cfg_r.pulse_ticks        <= uerd_pkg::PULSE_RST;
      cfg_r.echo_timeout_ticks <= uerd_pkg::TIMEOUT_RST;
      cfg_r.ticks_per_unit     <= uerd_pkg::TPU_RST;
      cfg_r.repeat_gap_ticks   <= uerd_pkg::GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        uerd_pkg::CFG_SETTLE:  cfg_r.settle_ticks       <= cfg_data[15:0];
        uerd_pkg::CFG_PULSE:   cfg_r.pulse_ticks        <= cfg_data[15:0];
        uerd_pkg::CFG_TIMEOUT: cfg_r.echo_timeout_ticks <= cfg_data;
        uerd_pkg::CFG_TPU:     cfg_r.ticks_per_unit     <= cfg_data[15:0];
        uerd_pkg::CFG_GAP:     cfg_r.repeat_gap_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  uerd_disp u_disp (
    .bcd      (bcd),
    .seg_word (seg_word),
    .distance (seg_distance)
  );

  uerd_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .echo_level   (in_tdata[0]),
    .cfg          (cfg_r),
    .seg_word     (seg_word),
    .seg_distance (seg_distance),
    .bcd          (bcd),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {3'd0, res.new_reading, res.timed_out, res.distance_units,
                     res.display_word, res.trigger_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/uerd_checker.sv
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
// Depends on uerd_pkg and ultrasonic_echo_ranger_display_top_assert.svh.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_display_top_assert.svh"

module uerd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic stalled;
  logic shown_tmo;
  logic shown_num;
  logic dash_ok;
  logic num_ok;

  assign stalled   = out_tvalid && !out_tready;
  assign shown_tmo = out_tvalid && out_tdata[43];
  assign shown_num = out_tvalid && !out_tdata[43];
  assign dash_ok   = (out_tdata[32:1] == uerd_pkg::DASHES) && (out_tdata[42:33] == 10'd0);
  assign num_ok    = (out_tdata[42:33] <= 10'd999) && (out_tdata[32:25] == 8'h00);

  `UERD_ASSERT_NXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata), "stalled result changed")
  `UERD_ASSERT_IMP(a_no_bubble, !out_tvalid, in_tready, "input stalled with empty output")
  `UERD_ASSERT_NXT(a_out_fill, in_tvalid && in_tready, out_tvalid, "accepted request lost")
  `UERD_ASSERT_IMP(a_dash_word, shown_tmo, dash_ok, "timeout reading not dashes")
  `UERD_ASSERT_IMP(a_dist_range, shown_num, num_ok, "distance reading malformed")

endmodule

bind ultrasonic_echo_ranger_display_top uerd_checker u_uerd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
